// ===== design/lpfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package lpfd_pkg;

    localparam int DATA_W = 8;
    localparam int LEN_W  = 25;

    localparam logic [DATA_W-1:0] FLAG_BYTE    = 8'hA5;
    localparam logic [DATA_W-1:0] TRAILER_BYTE = 8'h5A;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 25'd65536;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CHECK,
        PH_LEN0,
        PH_LEN1,
        PH_LEN2,
        PH_LEN3,
        PH_PAYLOAD,
        PH_TRAILER
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_GOOD,
        KIND_LEN_ERR,
        KIND_TRL_ERR
    } kind_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  length;
    } res_t;

endpackage

// ===== design/lpfd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_if
// Valid/ready channels: received bytes, deframer results, configuration.
// ----------------------------------------------------------------------------
interface lpfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfd_tx_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_data;
    logic [24:0] out_length;

    modport source (output valid, output out_kind, output out_data, output out_length,
                    input ready);
    modport sink   (input valid, input out_kind, input out_data, input out_length,
                    output ready);
endinterface

interface lpfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [24:0] max_payload;

    modport source (output valid, output max_payload, input ready);
    modport sink   (input valid, input max_payload, output ready);
endinterface

// ===== design/lpfd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_parser
// Frame phase machine, length gathering and per-byte result decode.
// ----------------------------------------------------------------------------
module lpfd_parser
    import lpfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [DATA_W-1:0] rx_byte,
    input  logic [LEN_W-1:0]  max_payload,
    output res_t              res
);

    phase_t            phase_reg, phase_next;
    logic [23:0]       lf_reg;
    logic [LEN_W-1:0]  plen_reg;
    logic [LEN_W-1:0]  left_reg;

    logic [31:0]       full_len;
    logic              len_err;
    logic [LEN_W-1:0]  plen_new;
    logic [LEN_W-1:0]  left_dec;

    assign full_len = {rx_byte, lf_reg};
    // length + 1 > max  <=>  length >= max
    assign len_err  = full_len >= {7'd0, max_payload};
    assign plen_new = full_len[LEN_W-1:0] + {{(LEN_W-1){1'b0}}, 1'b1};
    assign left_dec = (left_reg != '0) ? left_reg - {{(LEN_W-1){1'b0}}, 1'b1} : '0;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:    phase_next = (rx_byte == FLAG_BYTE) ? PH_CHECK : PH_HUNT;
                PH_CHECK:   phase_next = PH_LEN0;
                PH_LEN0:    phase_next = PH_LEN1;
                PH_LEN1:    phase_next = PH_LEN2;
                PH_LEN2:    phase_next = PH_LEN3;
                PH_LEN3:    phase_next = len_err ? PH_HUNT : PH_PAYLOAD;
                PH_PAYLOAD: phase_next = (left_dec == '0) ? PH_TRAILER : PH_PAYLOAD;
                PH_TRAILER: phase_next = PH_HUNT;
                default:    phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb
    begin
        res.valid  = 1'b0;
        res.kind   = KIND_DATA;
        res.data   = '0;
        res.length = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN3:
                begin
                    if (len_err)
                    begin
                        res.valid = 1'b1;
                        res.kind  = KIND_LEN_ERR;
                    end
                end
                PH_PAYLOAD:
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_DATA;
                    res.data  = rx_byte;
                end
                PH_TRAILER:
                begin
                    res.valid = 1'b1;
                    if (rx_byte == TRAILER_BYTE)
                    begin
                        res.kind   = KIND_GOOD;
                        res.length = plen_reg;
                    end
                    else
                    begin
                        res.kind = KIND_TRL_ERR;
                    end
                end
                default:
                begin
                    res.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            lf_reg    <= '0;
            plen_reg  <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (accept)
            begin
                case (phase_reg)
                    PH_LEN0: lf_reg <= {16'd0, rx_byte};
                    PH_LEN1: lf_reg[15:8]  <= rx_byte;
                    PH_LEN2: lf_reg[23:16] <= rx_byte;
                    PH_LEN3:
                    begin
                        if (!len_err)
                        begin
                            plen_reg <= plen_new;
                            left_reg <= plen_new;
                        end
                    end
                    PH_PAYLOAD: left_reg <= left_dec;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== design/lpfd_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_out_buf
// Output register with skid stage; input ready is registered.
// ----------------------------------------------------------------------------
module lpfd_out_buf
    import lpfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_t      res,
    output logic      in_ready,
    lpfd_tx_if.source tx
);

    res_t main_reg, main_next;
    res_t skid_reg, skid_next;
    logic push;
    logic pop;

    assign in_ready = !skid_reg.valid;
    assign push     = res.valid && in_ready;
    assign pop      = main_reg.valid && tx.ready;

    always_comb
    begin
        main_next = main_reg;
        skid_next = skid_reg;
        if (pop)
        begin
            if (skid_reg.valid)
            begin
                main_next       = skid_reg;
                skid_next       = res;
                skid_next.valid = push;
            end
            else
            begin
                main_next       = res;
                main_next.valid = push;
            end
        end
        else if (push)
        begin
            if (main_reg.valid)
            begin
                skid_next = res;
            end
            else
            begin
                main_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_reg <= '0;
            skid_reg <= '0;
        end
        else
        begin
            main_reg <= main_next;
            skid_reg <= skid_next;
        end
    end

    assign tx.valid      = main_reg.valid;
    assign tx.out_kind   = main_reg.kind;
    assign tx.out_data   = main_reg.data;
    assign tx.out_length = main_reg.length;

endmodule

// ===== design/length_prefixed_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_unit
// Flag/length/trailer frame deframer, one received byte per clock while rx is ready.
// ----------------------------------------------------------------------------
// Takes one byte per clock on rx while rx ready is high. Each byte is decoded
// in the cycle it is accepted by the phase machine and any result (payload
// byte, good end, length error, trailer error) lands in the output register,
// or in the skid entry while that register is full; tx is driven from the
// output register. The two-entry register/skid pair keeps rx ready after tx
// stalls; rx ready drops only while both entries hold results, and then no
// byte is taken. The user must write max_payload on cfg (always ready) only
// while the block is idle; the block does not enforce this. Reset value is 65536.
module length_prefixed_frame_deframer_unit
    import lpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lpfd_cfg_if.sink   cfg,
    lpfd_rx_if.sink    rx,
    lpfd_tx_if.source  tx
);

    logic [LEN_W-1:0] max_payload_reg;
    logic             accept;
    logic             in_ready;
    res_t             res;

    assign cfg.ready = 1'b1;
    assign rx.ready  = in_ready;
    assign accept    = rx.valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg.valid)
        begin
            max_payload_reg <= cfg.max_payload;
        end
    end

    lpfd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx.rx_byte),
        .max_payload (max_payload_reg),
        .res         (res)
    );

    lpfd_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .in_ready (in_ready),
        .tx       (tx)
    );

endmodule
